// ----- hdl/sst_pkg.sv -----
package sst_pkg;

  localparam int FUNC_W  = 3;
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 4;
  localparam int STAT_W  = 3;

  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  localparam logic [FUNC_W-1:0] FN_CLEAR    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ADD      = 3'd1;
  localparam logic [FUNC_W-1:0] FN_ERASE    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_CONTAINS = 3'd3;
  localparam logic [FUNC_W-1:0] FN_GET      = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP    = 3'd2;
  localparam logic [STAT_W-1:0] ST_ABSENT = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_EXEC,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_GET,
    S_DONE
  } state_t;

endpackage

// ----- hdl/sorted_set_table.sv -----
// Sorted set of distinct signed 32-bit values held in one synchronous RAM in
// ascending order. An operation arrives on the in_ channel (func, value, index)
// and produces exactly one transfer on the out_ channel carrying the smallest
// member, the member count, whether value was a member beforehand, the entry
// read by a get, and a status code.
// One operation is handled at a time; in_stall is high from the accepted
// transfer until the result has been loaded into the output register.
// Every operation first scans the table from position 0 until it meets an
// entry not below value or reaches the count, reading each entry visited from
// RAM and then comparing it. A successful add then moves every entry above the
// insertion point up by one and an erase of a member moves every entry above
// the removed one down by one, reading each moved entry and writing it back.
// A get with an index below the count reads that entry through state S_GET.
// The next operation can be accepted in the cycle after the result is loaded.
// The output register holds a finished result while out_stall is high; the
// next operation is accepted meanwhile and waits at its end for the register.
// Synchronous reset empties the set and drops any result not yet transferred.
// No clearing pass is needed; RAM contents are only read below the count.
module sorted_set_table #(
  parameter int CAPACITY = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic        [sst_pkg::FUNC_W-1:0]     in_func,
  input  logic signed [sst_pkg::DATA_W-1:0]     in_value,
  input  logic        [sst_pkg::INDEX_W-1:0]    in_index,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [sst_pkg::DATA_W-1:0]     out_min_value,
  output logic        [$clog2(CAPACITY+1)-1:0]  out_count,
  output logic                                  out_found,
  output logic signed [sst_pkg::DATA_W-1:0]     out_read_value,
  output logic        [sst_pkg::STAT_W-1:0]     out_status
);
  import sst_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  logic signed [DATA_W-1:0] mem [CAPACITY];

  state_t state_r, state_nxt;

  logic        [FUNC_W-1:0]  func_r;
  logic signed [DATA_W-1:0]  value_r;
  logic        [INDEX_W-1:0] index_r;

  logic [CNT_W-1:0]         ptr_r, ptr_nxt;
  logic [CNT_W-1:0]         wp_r, wp_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     found_r, found_nxt;
  logic [STAT_W-1:0]        status_r, status_nxt;
  logic signed [DATA_W-1:0] read_r, read_nxt;
  logic signed [DATA_W-1:0] min_r, min_nxt;
  logic signed [DATA_W-1:0] rd_data_r;

  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic signed [DATA_W-1:0] mem_wdata;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_min_r, out_read_r;
  logic [CNT_W-1:0]         out_count_r;
  logic                     out_found_r;
  logic [STAT_W-1:0]        out_status_r;

  logic in_take, out_free, out_load;
  logic rd_eq, rd_gt, full, idx_ok, del_last, ins_here;

  assign in_take  = (state_r == S_IDLE) && in_valid;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_DONE) && out_free;
  assign rd_eq    = (rd_data_r == value_r);
  assign rd_gt    = (value_r < rd_data_r);
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign idx_ok   = (CMP_W'(index_r) < CMP_W'(count_r));
  assign del_last = ((wp_r + CNT_W'(1)) == count_r);
  assign ins_here = (wp_r == ptr_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_SCAN_RD;
      S_SCAN_RD:  state_nxt = (ptr_r == count_r) ? S_EXEC : S_SCAN_CHK;
      S_SCAN_CHK: state_nxt = (rd_eq || rd_gt) ? S_EXEC : S_SCAN_RD;
      S_EXEC: begin
        unique case (func_r)
          FN_ADD:   state_nxt = (found_r || full) ? S_DONE : S_INS_RD;
          FN_ERASE: state_nxt = found_r ? S_DEL_RD : S_DONE;
          FN_GET:   state_nxt = idx_ok ? S_GET : S_DONE;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_INS_RD:   state_nxt = ins_here ? S_DONE : S_INS_WR;
      S_INS_WR:   state_nxt = S_INS_RD;
      S_DEL_RD:   state_nxt = del_last ? S_DONE : S_DEL_WR;
      S_DEL_WR:   state_nxt = S_DEL_RD;
      S_GET:      state_nxt = S_DONE;
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ptr_nxt    = ptr_r;
    wp_nxt     = wp_r;
    count_nxt  = count_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    read_nxt   = read_r;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = value_r;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ptr_nxt    = '0;
          found_nxt  = 1'b0;
          status_nxt = ST_OK;
          read_nxt   = '0;
        end
      end
      S_SCAN_RD: begin
        if (ptr_r != count_r) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(ptr_r);
        end
      end
      S_SCAN_CHK: begin
        if (rd_eq) begin
          found_nxt = 1'b1;
        end else if (!rd_gt) begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end
      end
      S_EXEC: begin
        unique case (func_r)
          FN_CLEAR: count_nxt = '0;
          FN_ADD: begin
            if (found_r) begin
              status_nxt = ST_DUP;
            end else if (full) begin
              status_nxt = ST_FULL;
            end else begin
              wp_nxt = count_r;
            end
          end
          FN_ERASE: begin
            if (!found_r) begin
              status_nxt = ST_ABSENT;
            end else begin
              wp_nxt = ptr_r;
            end
          end
          FN_GET: begin
            if (idx_ok) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(index_r);
            end else begin
              status_nxt = ST_RANGE;
            end
          end
          default: ;
        endcase
      end
      S_INS_RD: begin
        if (ins_here) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(ptr_r);
          mem_wdata = value_r;
          count_nxt = count_r + CNT_W'(1);
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(wp_r - CNT_W'(1));
        end
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(wp_r);
        mem_wdata = rd_data_r;
        wp_nxt    = wp_r - CNT_W'(1);
      end
      S_DEL_RD: begin
        if (del_last) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(wp_r + CNT_W'(1));
        end
      end
      S_DEL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(wp_r);
        mem_wdata = rd_data_r;
        wp_nxt    = wp_r + CNT_W'(1);
      end
      S_GET:   read_nxt = rd_data_r;
      S_DONE:  ;
      default: ;
    endcase
  end

  // The smallest member is mirrored in a register whenever position 0 is written.
  always_comb begin
    min_nxt = min_r;
    if (mem_we && (mem_waddr == '0)) begin
      min_nxt = mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r  <= in_func;
      value_r <= in_value;
      index_r <= in_index;
    end
    ptr_r    <= ptr_nxt;
    wp_r     <= wp_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    read_r   <= read_nxt;
    min_r    <= min_nxt;
    if (out_load) begin
      out_min_r    <= (count_r != '0) ? min_r : INT_MAX;
      out_count_r  <= count_r;
      out_found_r  <= found_r;
      out_read_r   <= read_r;
      out_status_r <= status_r;
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_min_value  = out_min_r;
  assign out_count      = out_count_r;
  assign out_found      = out_found_r;
  assign out_read_value = out_read_r;
  assign out_status     = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("member count exceeds capacity");

  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_RD || state_r == S_SCAN_CHK) |-> !mem_we)
    else $error("table written during scan");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside completion");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("read and write issued in the same cycle");

endmodule
